// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, sampled on clk_i, off while rst_ni is low
`define GNCE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent this cycle implies consequent on the next edge
`define GNCE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gnce_pkg.sv -----
package gnce_pkg;

  // Config port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COST_W     = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_COST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COSTLY_COST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DANGER_COST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ZSTEP_COST  = 3'd6;

  // Item kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_EXPAND = 2'd2;

  // Cell types
  localparam logic [1:0] CELL_FREE   = 2'd0;
  localparam logic [1:0] CELL_BLOCK  = 2'd1;
  localparam logic [1:0] CELL_COSTLY = 2'd2;
  localparam logic [1:0] CELL_DANGER = 2'd3;

  // Neighbor directions, in visiting order
  typedef enum logic [2:0] {
    DIR_XP = 3'd0,
    DIR_XN = 3'd1,
    DIR_YP = 3'd2,
    DIR_YN = 3'd3,
    DIR_ZP = 3'd4,
    DIR_ZN = 3'd5
  } dir_e;

  typedef struct packed {
    logic [6:0]        grid_width;
    logic [6:0]        grid_height;
    logic [4:0]        grid_depth;
    logic [COST_W-1:0] plain_cost;
    logic [COST_W-1:0] costly_cost;
    logic [COST_W-1:0] danger_cost;
    logic [COST_W-1:0] zstep_cost;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    dir_e              direction;
    logic [5:0]        x;
    logic [5:0]        y;
    logic [3:0]        z;
    logic [1:0]        cell_type;
    logic [COST_W-1:0] cost;
    logic              last;
  } res_t;

endpackage

// ----- rtl/gnce_cfg.sv -----
module gnce_cfg
  import gnce_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register decode; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:  cfg_d.grid_width  = cfg_data_i[6:0];
        CFG_GRID_HEIGHT: cfg_d.grid_height = cfg_data_i[6:0];
        CFG_GRID_DEPTH:  cfg_d.grid_depth  = cfg_data_i[4:0];
        CFG_PLAIN_COST:  cfg_d.plain_cost  = cfg_data_i[COST_W-1:0];
        CFG_COSTLY_COST: cfg_d.costly_cost = cfg_data_i[COST_W-1:0];
        CFG_DANGER_COST: cfg_d.danger_cost = cfg_data_i[COST_W-1:0];
        CFG_ZSTEP_COST:  cfg_d.zstep_cost  = cfg_data_i[COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= 7'd64;
      cfg_q.grid_height <= 7'd64;
      cfg_q.grid_depth  <= 5'd16;
      cfg_q.plain_cost  <= 16'd256;
      cfg_q.costly_cost <= 16'd256;
      cfg_q.danger_cost <= 16'd256;
      cfg_q.zstep_cost  <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/gnce_cell_mem.sv -----
module gnce_cell_mem #(
  parameter int AW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [1:0]    wdata_i,
  output logic [1:0]    rdata_o
);

  logic [1:0] mem_q [0:(1<<AW)-1];
  logic [1:0] rdata_q;

  // Single port, read data registered and held until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gnce_seq.sv -----
module gnce_seq
  import gnce_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 16,
  parameter int COST_BITS  = 16,
  parameter int AW         = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    kind_i,
  input  logic [5:0]    pos_x_i,
  input  logic [5:0]    pos_y_i,
  input  logic [3:0]    pos_z_i,
  input  logic [1:0]    cell_value_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output res_t          res_o,
  output logic          mem_en_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_addr_o,
  output logic [1:0]    mem_wdata_o,
  input  logic [1:0]    mem_rdata_i
);

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int ZB = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [32:0] COST_MAX = 33'((34'd1 << COST_BITS) - 34'd1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_READ   = 4'b0100,
    S_EXPAND = 4'b1000
  } state_e;

  function automatic logic in_bounds(input logic [6:0] x, input logic [6:0] y,
                                     input logic [4:0] z, input cfg_t c);
    return (x < c.grid_width)  && (32'(x) < 32'(MAX_WIDTH))  &&
           (y < c.grid_height) && (32'(y) < 32'(MAX_HEIGHT)) &&
           (z < c.grid_depth)  && (32'(z) < 32'(MAX_DEPTH));
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] x, input logic [6:0] y,
                                              input logic [4:0] z);
    return {ZB'(z), YB'(y), XB'(x)};
  endfunction

  // Control state
  state_e          state_q, state_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;
  dir_e            dir_q, dir_d;
  logic            issue_done_q, issue_done_d;
  logic            s1_v_q, s1_v_d;
  logic            h_v_q, h_v_d;
  logic            out_v_q, out_v_d;

  // Payload
  logic [5:0]      x_q, x_d, y_q, y_d;
  logic [3:0]      z_q, z_d;
  logic            rd_inb_q, rd_inb_d;
  dir_e            s1_dir_q, s1_dir_d;
  logic [6:0]      s1_x_q, s1_x_d, s1_y_q, s1_y_d;
  logic [4:0]      s1_z_q, s1_z_d;
  res_t            h_q, h_d;
  res_t            out_q, out_d;

  // Neighbor of the current direction
  logic [6:0]      nb_x, nb_y;
  logic [4:0]      nb_z;
  logic            nb_under, nb_inb, in_inb;

  // Evaluation of the most recently read neighbor cell
  logic [COST_W-1:0] type_cost;
  logic [COST_W:0]   cost_sum;
  logic [32:0]       cost_sat;
  logic              zmove, qual, stall, out_free, push, acc;
  res_t              eval_res, push_res;

  always_comb begin
    nb_x     = {1'b0, x_q};
    nb_y     = {1'b0, y_q};
    nb_z     = {1'b0, z_q};
    nb_under = 1'b0;
    case (dir_q)
      DIR_XP: nb_x = {1'b0, x_q} + 7'd1;
      DIR_XN: begin
        nb_under = (x_q == '0);
        nb_x     = {1'b0, x_q} - 7'd1;
      end
      DIR_YP: nb_y = {1'b0, y_q} + 7'd1;
      DIR_YN: begin
        nb_under = (y_q == '0);
        nb_y     = {1'b0, y_q} - 7'd1;
      end
      DIR_ZP: nb_z = {1'b0, z_q} + 5'd1;
      DIR_ZN: begin
        nb_under = (z_q == '0);
        nb_z     = {1'b0, z_q} - 5'd1;
      end
      default: ;
    endcase
  end

  assign nb_inb = !nb_under && in_bounds(nb_x, nb_y, nb_z, cfg_i);
  assign in_inb = in_bounds({1'b0, pos_x_i}, {1'b0, pos_y_i}, {1'b0, pos_z_i}, cfg_i);

  // Base cost by type, layer penalty on z moves, saturate
  always_comb begin
    case (mem_rdata_i)
      CELL_COSTLY: type_cost = cfg_i.costly_cost;
      CELL_DANGER: type_cost = cfg_i.danger_cost;
      default:     type_cost = cfg_i.plain_cost;
    endcase
    zmove    = (s1_dir_q == DIR_ZP) || (s1_dir_q == DIR_ZN);
    cost_sum = {1'b0, type_cost} + (zmove ? {1'b0, cfg_i.zstep_cost} : '0);
    cost_sat = (33'(cost_sum) > COST_MAX) ? COST_MAX : 33'(cost_sum);

    eval_res.hit       = 1'b1;
    eval_res.direction = s1_dir_q;
    eval_res.x         = s1_x_q[5:0];
    eval_res.y         = s1_y_q[5:0];
    eval_res.z         = s1_z_q[3:0];
    eval_res.cell_type = mem_rdata_i;
    eval_res.cost      = cost_sat[COST_W-1:0];
    eval_res.last      = 1'b0;
  end

  assign out_free   = !out_v_q || out_ready_i;
  assign qual       = s1_v_q && (mem_rdata_i != CELL_BLOCK);
  // A qualifying neighbor displaces the held one; that needs a free output slot
  assign stall      = qual && h_v_q && !out_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    dir_d        = dir_q;
    issue_done_d = issue_done_q;
    s1_v_d       = s1_v_q;
    h_v_d        = h_v_q;
    x_d          = x_q;
    y_d          = y_q;
    z_d          = z_q;
    rd_inb_d     = rd_inb_q;
    s1_dir_d     = s1_dir_q;
    s1_x_d       = s1_x_q;
    s1_y_d       = s1_y_q;
    s1_z_d       = s1_z_q;
    h_d          = h_q;
    push         = 1'b0;
    push_res     = h_q;
    mem_en_o     = 1'b0;
    mem_we_o     = 1'b0;
    mem_addr_o   = cell_addr({1'b0, pos_x_i}, {1'b0, pos_y_i}, {1'b0, pos_z_i});
    mem_wdata_o  = cell_value_i;

    unique case (state_q)
      // Sweep the store to free after reset
      S_CLEAR: begin
        mem_en_o    = 1'b1;
        mem_we_o    = 1'b1;
        mem_addr_o  = clr_addr_q;
        mem_wdata_o = CELL_FREE;
        clr_addr_d  = clr_addr_q + AW'(1);
        if (clr_addr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (acc) begin
          x_d = pos_x_i;
          y_d = pos_y_i;
          z_d = pos_z_i;
          case (kind_i)
            KIND_WRITE: begin
              mem_en_o = in_inb;
              mem_we_o = 1'b1;
            end
            KIND_READ: begin
              mem_en_o = in_inb;
              rd_inb_d = in_inb;
              state_d  = S_READ;
            end
            KIND_EXPAND: begin
              dir_d        = DIR_XP;
              issue_done_d = 1'b0;
              s1_v_d       = 1'b0;
              h_v_d        = 1'b0;
              state_d      = S_EXPAND;
            end
            default: ;
          endcase
        end
      end

      // Read data is held by the memory until the output frees up
      S_READ: begin
        if (out_free) begin
          push               = 1'b1;
          push_res.hit       = rd_inb_q;
          push_res.direction = DIR_XP;
          push_res.x         = x_q;
          push_res.y         = y_q;
          push_res.z         = z_q;
          push_res.cell_type = rd_inb_q ? mem_rdata_i : CELL_BLOCK;
          push_res.cost      = '0;
          push_res.last      = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_EXPAND: begin
        // Evaluate the most recently read neighbor unless stalled
        if (s1_v_q && !stall) begin
          s1_v_d = 1'b0;
          if (qual) begin
            if (h_v_q) begin
              push          = 1'b1;
              push_res      = h_q;
              push_res.last = 1'b0;
            end
            h_d   = eval_res;
            h_v_d = 1'b1;
          end
        end
        // Issue the read for the next direction
        if (!stall && !issue_done_q) begin
          s1_v_d     = nb_inb;
          s1_dir_d   = dir_q;
          s1_x_d     = nb_x;
          s1_y_d     = nb_y;
          s1_z_d     = nb_z;
          mem_en_o   = nb_inb;
          mem_addr_o = cell_addr(nb_x, nb_y, nb_z);
          if (dir_q == DIR_ZN) begin
            issue_done_d = 1'b1;
          end else begin
            dir_d = dir_e'(dir_q + 3'd1);
          end
        end
        // Close the run: flag the held neighbor as last, or report a miss
        if (issue_done_q && !s1_v_q && out_free) begin
          push = 1'b1;
          if (h_v_q) begin
            push_res      = h_q;
            push_res.last = 1'b1;
          end else begin
            push_res.hit       = 1'b0;
            push_res.direction = DIR_XP;
            push_res.x         = x_q;
            push_res.y         = y_q;
            push_res.z         = z_q;
            push_res.cell_type = CELL_FREE;
            push_res.cost      = '0;
            push_res.last      = 1'b1;
          end
          h_v_d   = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (push) begin
      out_v_d = 1'b1;
      out_d   = push_res;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_addr_q   <= '0;
      dir_q        <= DIR_XP;
      issue_done_q <= 1'b0;
      s1_v_q       <= 1'b0;
      h_v_q        <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      dir_q        <= dir_d;
      issue_done_q <= issue_done_d;
      s1_v_q       <= s1_v_d;
      h_v_q        <= h_v_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    rd_inb_q <= rd_inb_d;
    s1_dir_q <= s1_dir_d;
    s1_x_q   <= s1_x_d;
    s1_y_q   <= s1_y_d;
    s1_z_q   <= s1_z_d;
    h_q      <= h_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

// ----- rtl/grid3d_neighbor_cost_expand.sv -----
// Six-neighbor expansion over a 3D grid of 2-bit cell types.
// Input channel (in_valid_i/in_ready_o) takes one beat per item: kind_i selects
// write cell, read cell or expand; kind 3 is consumed and dropped.
// Output channel (out_valid_o/out_ready_i) gives result beats; last_o marks the
// final beat of an item. A write gives no beat, a read gives one, an expand
// gives one beat per passable in-bounds neighbor (+x,-x,+y,-y,+z,-z) or a
// single hit_o=0 beat when none qualifies.
// Config port: cfg_we_i writes cfg_data_i into register cfg_index_i at once.
// A write leaves the block idle; a read waits in the read state until the output
// register is free, then pushes its result beat; an expand issues one neighbor
// read per cycle through the single port of the cell memory, +x to -z, held
// while a stalled output blocks a displaced neighbor, then evaluates the last
// read (skipped when the -z neighbor is out of bounds) and closes the run.
// After reset the block sweeps the cell memory to free, one cell per cycle,
// with in_ready_o low; config writes are taken meanwhile.
// A stalled receiver holds the output register; the sequencer waits on it and
// resumes without loss. The next item is accepted while a beat still waits.
module grid3d_neighbor_cost_expand
  import gnce_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_DEPTH  = 16,
  parameter int COST_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [5:0]            pos_x_i,
  input  logic [5:0]            pos_y_i,
  input  logic [3:0]            pos_z_i,
  input  logic [1:0]            cell_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic [2:0]            direction_o,
  output logic [5:0]            out_x_o,
  output logic [5:0]            out_y_o,
  output logic [3:0]            out_z_o,
  output logic [1:0]            out_cell_o,
  output logic [COST_W-1:0]     move_cost_o,
  output logic                  last_o
);

  localparam int XB = $clog2(MAX_WIDTH);
  localparam int YB = $clog2(MAX_HEIGHT);
  localparam int ZB = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int AW = XB + YB + ZB;

  cfg_t          cfg;
  res_t          res;
  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [1:0]    mem_wdata, mem_rdata;

  gnce_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gnce_cell_mem #(
    .AW (AW)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  gnce_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH),
    .COST_BITS  (COST_BITS),
    .AW         (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .cell_value_i (cell_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res),
    .mem_en_o     (mem_en),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata)
  );

  // Result fields out to the ports
  assign hit_o       = res.hit;
  assign direction_o = res.direction;
  assign out_x_o     = res.x;
  assign out_y_o     = res.y;
  assign out_z_o     = res.z;
  assign out_cell_o  = res.cell_type;
  assign move_cost_o = res.cost;
  assign last_o      = res.last;

endmodule

// ----- rtl/gnce_checker.sv -----
`include "assert_macros.svh"

module gnce_checker
  import gnce_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        kind_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              hit_o,
  input logic [2:0]        direction_o,
  input logic [5:0]        out_x_o,
  input logic [1:0]        out_cell_o,
  input logic [COST_W-1:0] move_cost_o,
  input logic              last_o
);

  // A stalled result beat holds
  `GNCE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(move_cost_o) && $stable(out_x_o) && $stable(last_o), "result beat changed under stall")

  // Misses and out-of-bounds reads always close their run
  `GNCE_ASSERT(a_miss_last, out_valid_o && !hit_o |-> last_o, "beat with hit low not marked last")

  // A miss carries no cost and no direction
  `GNCE_ASSERT(a_miss_clean, out_valid_o && !hit_o |-> move_cost_o == '0 && direction_o == '0, "miss beat with cost or direction")

  // Expansion never emits a blocking cell, so a blocking hit is a read and is last
  `GNCE_ASSERT(a_block_last, out_valid_o && hit_o && out_cell_o == CELL_BLOCK |-> last_o, "blocking cell beat not last")

  // An expand keeps the block busy, with in_ready_o low right after its accept
  `GNCE_ASSERT_NEXT(a_expand_busy, in_valid_i && in_ready_o && kind_i == KIND_EXPAND, !in_ready_o, "ready right after an expand was accepted")

endmodule

bind grid3d_neighbor_cost_expand gnce_checker u_checker (.*);

// ----- verif/tb_grid3d_neighbor_cost_expand.sv -----
module tb_grid3d_neighbor_cost_expand
  import gnce_pkg::*;
();

  localparam int GRID_X        = 64;
  localparam int GRID_Y        = 64;
  localparam int GRID_Z        = 16;
  localparam int NUM_DIRS      = 6;
  localparam int SETTLE_CYCLES = 16;
  // the post-reset memory sweep holds off input, so the limit must outlast it
  localparam int IDLE_LIMIT    = 200000;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] x;
    logic [5:0] y;
    logic [3:0] z;
    logic [1:0] val;
  } grid_cmd_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            kind_i;
  logic [5:0]            pos_x_i;
  logic [5:0]            pos_y_i;
  logic [3:0]            pos_z_i;
  logic [1:0]            cell_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  hit_o;
  logic [2:0]            direction_o;
  logic [5:0]            out_x_o;
  logic [5:0]            out_y_o;
  logic [3:0]            out_z_o;
  logic [1:0]            out_cell_o;
  logic [COST_W-1:0]     move_cost_o;
  logic                  last_o;

  grid_cmd_t  cmd_q [$];
  res_t       neighbor_beats_q [$];
  logic [1:0] grid_mem [0:GRID_X*GRID_Y*GRID_Z-1];
  cfg_t       grid_cfg;
  grid_cmd_t  drv_cmd;
  bit         stall_en;
  logic       in_beat_q;
  logic       out_beat_q;
  int         in_gap;
  int         out_stall;
  int         n_pushed;
  int         n_accepted;
  int         n_beats;
  int         n_fail;
  int         n_phases;
  int         idle_cycles;
  int         kind_seen [4];

  grid3d_neighbor_cost_expand dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .cell_value_i (cell_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .direction_o  (direction_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_cell_o   (out_cell_o),
    .move_cost_o  (move_cost_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Grid model
  // ---------------------------------------------------------------------------

  function automatic bit in_grid(input int x, input int y, input int z);
    return x >= 0 && x < int'(grid_cfg.grid_width) && x < GRID_X &&
           y >= 0 && y < int'(grid_cfg.grid_height) && y < GRID_Y &&
           z >= 0 && z < int'(grid_cfg.grid_depth) && z < GRID_Z;
  endfunction

  function automatic int cell_addr(input int x, input int y, input int z);
    return (z * GRID_Y + y) * GRID_X + x;
  endfunction

  function automatic void step_pos(input dir_e dir, inout int x, inout int y, inout int z);
    case (dir)
      DIR_XP: x++;
      DIR_XN: x--;
      DIR_YP: y++;
      DIR_YN: y--;
      DIR_ZP: z++;
      default: z--;
    endcase
  endfunction

  // Updates the grid and queues the beats one accepted item will produce
  task automatic predict_item(input logic [1:0] kind, input int x, input int y, input int z,
                              input logic [1:0] val);
    res_t              beat;
    res_t              held;
    bit                have_held;
    int                d;
    int                nx;
    int                ny;
    int                nz;
    dir_e              dir;
    logic [1:0]        t;
    logic [COST_W-1:0] base;
    logic [COST_W:0]   sum;
    beat      = '0;
    beat.x    = 6'(x);
    beat.y    = 6'(y);
    beat.z    = 4'(z);
    beat.last = 1'b1;
    case (kind)
      KIND_WRITE: begin
        if (in_grid(x, y, z)) grid_mem[cell_addr(x, y, z)] = val;
      end
      KIND_READ: begin
        beat.hit       = in_grid(x, y, z);
        beat.cell_type = beat.hit ? grid_mem[cell_addr(x, y, z)] : CELL_BLOCK;
        neighbor_beats_q.insert(neighbor_beats_q.size(), beat);
      end
      KIND_EXPAND: begin
        have_held = 1'b0;
        held      = '0;
        for (d = 0; d < NUM_DIRS; d++) begin
          dir = dir_e'(d);
          nx  = x;
          ny  = y;
          nz  = z;
          step_pos(dir, nx, ny, nz);
          if (in_grid(nx, ny, nz) && grid_mem[cell_addr(nx, ny, nz)] != CELL_BLOCK) begin
            t = grid_mem[cell_addr(nx, ny, nz)];
            case (t)
              CELL_COSTLY: base = grid_cfg.costly_cost;
              CELL_DANGER: base = grid_cfg.danger_cost;
              default:     base = grid_cfg.plain_cost;
            endcase
            sum = {1'b0, base};
            if (dir == DIR_ZP || dir == DIR_ZN) sum = sum + {1'b0, grid_cfg.zstep_cost};
            // a beat is only known not to be the last once another one follows
            if (have_held) neighbor_beats_q.insert(neighbor_beats_q.size(), held);
            held           = '0;
            held.hit       = 1'b1;
            held.direction = dir;
            held.x         = 6'(nx);
            held.y         = 6'(ny);
            held.z         = 4'(nz);
            held.cell_type = t;
            held.cost      = sum[COST_W] ? '1 : sum[COST_W-1:0];
            have_held      = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          neighbor_beats_q.insert(neighbor_beats_q.size(), held);
        end else begin
          neighbor_beats_q.insert(neighbor_beats_q.size(), beat);
        end
      end
      default: ;
    endcase
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_fail++;
    end
  endtask

  task automatic check_beat();
    res_t want;
    if (neighbor_beats_q.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual hit=%0b dir=%0d pos=(%0d,%0d,%0d)",
               $time, hit_o, direction_o, out_x_o, out_y_o, out_z_o);
      n_fail++;
      return;
    end
    want = neighbor_beats_q.pop_front();
    cmp_field("hit", 16'(want.hit), 16'(hit_o));
    cmp_field("direction", 16'(want.direction), 16'(direction_o));
    cmp_field("out_x", 16'(want.x), 16'(out_x_o));
    cmp_field("out_y", 16'(want.y), 16'(out_y_o));
    cmp_field("out_z", 16'(want.z), 16'(out_z_o));
    cmp_field("out_cell", 16'(want.cell_type), 16'(out_cell_o));
    cmp_field("move_cost", want.cost, move_cost_o);
    cmp_field("last", 16'(want.last), 16'(last_o));
    n_beats++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    in_beat_q  <= rst_ni && in_valid_i && in_ready_o === 1'b1;
    out_beat_q <= rst_ni && out_ready_i && out_valid_o === 1'b1;
    if (rst_ni && out_ready_i && out_valid_o === 1'b1) check_beat();
    if (rst_ni && in_valid_i && in_ready_o === 1'b1) begin
      n_accepted++;
      kind_seen[kind_i]++;
      predict_item(kind_i, int'(pos_x_i), int'(pos_y_i), int'(pos_z_i), cell_value_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: items from cmd_q, random gaps on input and stalls on output
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (!stall_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // slot is free when nothing is offered or the last beat went in
      if (!in_valid_i || in_beat_q) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (cmd_q.size() > 0) begin
          drv_cmd = cmd_q.pop_front();
          in_valid_i   <= 1'b1;
          kind_i       <= drv_cmd.kind;
          pos_x_i      <= drv_cmd.x;
          pos_y_i      <= drv_cmd.y;
          pos_z_i      <= drv_cmd.z;
          cell_value_i <= drv_cmd.val;
          in_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_ready_i <= 1'b0;
        out_stall--;
      end else begin
        out_ready_i <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // Watchdog on cycles without any beat
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk_i);
      if (in_beat_q || out_beat_q) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_item(input logic [1:0] kind, input int x, input int y, input int z,
                           input logic [1:0] val);
    grid_cmd_t c;
    c.kind = kind;
    c.x    = 6'(x);
    c.y    = 6'(y);
    c.z    = 4'(z);
    c.val  = val;
    cmd_q.insert(cmd_q.size(), c);
    n_pushed++;
  endtask

  // All items taken, all beats seen, then time for a trailing write to land
  task automatic wait_idle();
    while (n_pushed != n_accepted || neighbor_beats_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_GRID_WIDTH:  grid_cfg.grid_width  = data[6:0];
      CFG_GRID_HEIGHT: grid_cfg.grid_height = data[6:0];
      CFG_GRID_DEPTH:  grid_cfg.grid_depth  = data[4:0];
      CFG_PLAIN_COST:  grid_cfg.plain_cost  = data;
      CFG_COSTLY_COST: grid_cfg.costly_cost = data;
      CFG_DANGER_COST: grid_cfg.danger_cost = data;
      CFG_ZSTEP_COST:  grid_cfg.zstep_cost  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_cfg(input logic [15:0] w, input logic [15:0] h, input logic [15:0] d,
                         input logic [15:0] fc, input logic [15:0] cc, input logic [15:0] dc,
                         input logic [15:0] lp);
    wait_idle();
    n_phases++;
    cfg_write(CFG_GRID_WIDTH, w);
    cfg_write(CFG_GRID_HEIGHT, h);
    cfg_write(CFG_GRID_DEPTH, d);
    cfg_write(CFG_PLAIN_COST, fc);
    cfg_write(CFG_COSTLY_COST, cc);
    cfg_write(CFG_DANGER_COST, dc);
    cfg_write(CFG_ZSTEP_COST, lp);
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_size(input int hi);
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, hi);
    return $urandom_range(1, hi / 4 + 2);
  endfunction

  task automatic random_cfg();
    set_cfg(16'(pick_size(GRID_X)), 16'(pick_size(GRID_Y)), 16'(pick_size(GRID_Z)),
            pick_cost(), pick_cost(), pick_cost(), pick_cost());
  endtask

  // Mostly neighborhoods: writes around a center, then expand it and maybe
  // read back one neighbor. The rest is raw noise over every field value.
  task automatic random_phase(input int n_items);
    int   cnt;
    int   cx;
    int   cy;
    int   cz;
    int   nx;
    int   ny;
    int   nz;
    int   d;
    int   hx;
    int   hy;
    int   hz;
    grid_cmd_t c;
    cnt = 0;
    hx  = int'(grid_cfg.grid_width) < GRID_X ? int'(grid_cfg.grid_width) : GRID_X - 1;
    hy  = int'(grid_cfg.grid_height) < GRID_Y ? int'(grid_cfg.grid_height) : GRID_Y - 1;
    hz  = int'(grid_cfg.grid_depth) < GRID_Z ? int'(grid_cfg.grid_depth) : GRID_Z - 1;
    while (cnt < n_items) begin
      if ($urandom_range(0, 99) < 75) begin
        cx = $urandom_range(0, hx);
        cy = $urandom_range(0, hy);
        cz = $urandom_range(0, hz);
        if ($urandom_range(0, 9) == 0) begin
          // wall the center in completely
          for (d = 0; d < NUM_DIRS; d++) begin
            nx = cx;
            ny = cy;
            nz = cz;
            step_pos(dir_e'(d), nx, ny, nz);
            push_item(KIND_WRITE, nx, ny, nz, CELL_BLOCK);
            cnt++;
          end
        end else begin
          repeat ($urandom_range(0, 4)) begin
            nx = cx;
            ny = cy;
            nz = cz;
            step_pos(dir_e'($urandom_range(0, NUM_DIRS - 1)), nx, ny, nz);
            push_item(KIND_WRITE, nx, ny, nz, 2'($urandom));
            cnt++;
          end
        end
        push_item(KIND_EXPAND, cx, cy, cz, 2'($urandom));
        cnt++;
        if ($urandom_range(0, 2) == 0) begin
          nx = cx;
          ny = cy;
          nz = cz;
          step_pos(dir_e'($urandom_range(0, NUM_DIRS - 1)), nx, ny, nz);
          push_item(KIND_READ, nx, ny, nz, 2'($urandom));
          cnt++;
        end
      end else begin
        c = grid_cmd_t'(20'($urandom));
        push_item(c.kind, int'(c.x), int'(c.y), int'(c.z), c.val);
        if (c.kind != KIND_UNUSED) cnt++;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_WRITE;
    pos_x_i      = '0;
    pos_y_i      = '0;
    pos_z_i      = '0;
    cell_value_i = CELL_FREE;
    out_ready_i  = 1'b0;
    in_beat_q    = 1'b0;
    out_beat_q   = 1'b0;
    in_gap       = 0;
    out_stall    = 0;
    n_pushed     = 0;
    n_accepted   = 0;
    n_beats      = 0;
    n_fail       = 0;
    n_phases     = 0;
    stall_en     = 1'b1;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    foreach (grid_mem[i]) grid_mem[i] = CELL_FREE;
    grid_cfg.grid_width  = 7'd64;
    grid_cfg.grid_height = 7'd64;
    grid_cfg.grid_depth  = 5'd16;
    grid_cfg.plain_cost  = 16'h0100;
    grid_cfg.costly_cost = 16'h0100;
    grid_cfg.danger_cost = 16'h0100;
    grid_cfg.zstep_cost  = 16'h0000;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: small 8x6x3 grid, danger plus penalty saturates
    set_cfg(16'd8, 16'd6, 16'd3, 16'h0100, 16'h0280, 16'hFF00, 16'h0180);
    push_item(KIND_READ, 0, 0, 0, CELL_FREE);          // fresh cell after reset
    push_item(KIND_READ, 8, 0, 0, CELL_FREE);          // just past the x edge
    push_item(KIND_READ, 63, 63, 15, CELL_DANGER);     // field maxima, out of bounds
    push_item(KIND_WRITE, 1, 0, 0, CELL_COSTLY);
    push_item(KIND_WRITE, 0, 1, 0, CELL_DANGER);
    push_item(KIND_WRITE, 0, 0, 1, CELL_BLOCK);
    push_item(KIND_EXPAND, 0, 0, 0, CELL_FREE);        // low corner, +z blocked
    push_item(KIND_EXPAND, 7, 5, 2, CELL_FREE);        // high corner, -z with penalty
    push_item(KIND_WRITE, 2, 2, 1, CELL_DANGER);
    push_item(KIND_EXPAND, 2, 2, 0, CELL_FREE);        // +z cost saturates
    push_item(KIND_READ, 2, 2, 1, CELL_FREE);
    push_item(KIND_EXPAND, 40, 40, 10, CELL_FREE);     // far outside: no neighbor
    push_item(KIND_WRITE, 1, 0, 0, CELL_BLOCK);
    push_item(KIND_WRITE, 0, 1, 0, CELL_BLOCK);
    push_item(KIND_EXPAND, 0, 0, 0, CELL_FREE);        // boxed in by edges and blocks
    push_item(KIND_WRITE, 9, 0, 0, CELL_DANGER);       // out of bounds, dropped
    push_item(KIND_UNUSED, 63, 63, 15, CELL_DANGER);   // unused kind, no beat
    push_item(KIND_WRITE, 7, 4, 2, CELL_COSTLY);
    push_item(KIND_EXPAND, 7, 5, 2, CELL_DANGER);
    push_item(KIND_READ, 7, 4, 2, CELL_FREE);

    // Full grid; width/height/depth written past the field or the maximum
    set_cfg(16'hFFC0, 16'd127, 16'h001F, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF);
    stall_en = 1'b1;
    push_item(KIND_READ, 9, 0, 0, CELL_FREE);          // dropped write left it free
    push_item(KIND_READ, 2, 2, 1, CELL_FREE);
    push_item(KIND_EXPAND, 63, 63, 15, CELL_FREE);
    push_item(KIND_EXPAND, 32, 32, 8, CELL_FREE);
    random_phase(140);

    // Single cell grid: every expand finds nothing
    set_cfg(16'd1, 16'd1, 16'd1, pick_cost(), pick_cost(), pick_cost(), pick_cost());
    stall_en = 1'b0;
    random_phase(25);

    // Zero width: nothing in bounds
    set_cfg(16'd0, 16'd64, 16'd16, pick_cost(), pick_cost(), pick_cost(), pick_cost());
    stall_en = 1'b1;
    random_phase(20);

    repeat (4) begin
      random_cfg();
      stall_en = $urandom_range(0, 2) != 0;
      random_phase(60);
    end

    wait_idle();
    $display("covered %0d writes, %0d reads, %0d expands, %0d unused-kind items, %0d settings",
             kind_seen[KIND_WRITE], kind_seen[KIND_READ], kind_seen[KIND_EXPAND],
             kind_seen[KIND_UNUSED], n_phases);
    $display("checked %0d result beats, %0d mismatches", n_beats, n_fail);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
